// ----- rtl/core/gcpc_pkg.sv -----
package gcpc_pkg;

   localparam int ACT_W     = 2;
   localparam int VERTEX_W  = 32;
   localparam int LCC_W     = 8;
   localparam int SIZE_W    = 16;
   localparam int CNT_OUT_W = 16;

   localparam int DEF_COMPONENT_COUNT = 256;
   localparam int DEF_GROUP_DEPTH     = 16;
   localparam int DEF_COUNT_WIDTH     = 16;

   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FINISH = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

   localparam logic KIND_CLONE = 1'b0;
   localparam logic KIND_CELL  = 1'b1;

   // matrix access issued this cycle
   typedef struct packed {
      logic vld;
      logic rd;
      logic ok;
   } cell_req_type;

   // matrix read data ready this cycle
   typedef struct packed {
      logic vld;
      logic ok;
   } cell_done_type;

endpackage

// ----- rtl/core/gcpc_ram.sv -----
module gcpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word when the same address is written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/gcpc_cell_unit.sv -----
module gcpc_cell_unit
   import gcpc_pkg::*;
#(
   parameter int ADDR_W      = 16,
   parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_req_type           req,
   input  logic [ADDR_W-1:0]      req_addr,
   output logic                   clearing,
   output cell_done_type          done,
   output logic [COUNT_WIDTH-1:0] done_count
);

   localparam int DEPTH = 1 << ADDR_W;

   logic                   clr_act_ff, clr_act_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic                   c_vld_ff, c_rd_ff, c_ok_ff;
   logic [ADDR_W-1:0]      c_addr_ff;
   logic                   w_vld_ff, w_vld_in;
   logic [ADDR_W-1:0]      w_addr_ff, w_addr_in;
   logic [COUNT_WIDTH-1:0] w_data_ff, w_data_in;
   logic [COUNT_WIDTH-1:0] mem_rdata, cur_val, inc_val;
   logic                   upd_go;

   gcpc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_matrix (
      .clock   (clock),
      .wr_en   (w_vld_in),
      .wr_addr (w_addr_in),
      .wr_data (w_data_in),
      .rd_en   (req.vld),
      .rd_addr (req_addr),
      .rd_data (mem_rdata)
   );

   // forward the write of the previous cycle, the read issued then missed it
   assign cur_val = (w_vld_ff && (w_addr_ff == c_addr_ff)) ? w_data_ff : mem_rdata;
   assign inc_val = (cur_val == '1) ? cur_val : cur_val + 1'b1;
   assign upd_go  = c_vld_ff && !c_rd_ff && c_ok_ff;

   always_comb begin
      clr_addr_in = clr_addr_ff + 1'b1;
      clr_act_in  = clr_act_ff && (clr_addr_ff != '1);
      if (clr_act_ff) begin
         w_vld_in  = 1'b1;
         w_addr_in = clr_addr_ff;
         w_data_in = '0;
      end else begin
         w_vld_in  = upd_go;
         w_addr_in = c_addr_ff;
         w_data_in = inc_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_act_ff  <= 1'b1;
         clr_addr_ff <= '0;
         c_vld_ff    <= 1'b0;
         w_vld_ff    <= 1'b0;
      end else begin
         if (clr_act_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         clr_act_ff <= clr_act_in;
         c_vld_ff   <= req.vld;
         w_vld_ff   <= w_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      c_rd_ff   <= req.rd;
      c_ok_ff   <= req.ok;
      c_addr_ff <= req_addr;
      w_addr_ff <= w_addr_in;
      w_data_ff <= w_data_in;
   end

   assign clearing   = clr_act_ff;
   assign done.vld   = c_vld_ff && c_rd_ff;
   assign done.ok    = c_ok_ff;
   assign done_count = cur_val;

endmodule

// ----- rtl/core/group_cooccurrence_pair_counter_top.sv -----
// Channel   Ports                                    Handshake
// req       req_action, req_vertex_label,            beat taken when start && !busy
//           req_lcc_index, req_read_src, req_read_tgt
// rsp       rsp_result_kind, rsp_done_vertex,        beat shown for one cycle with
//           rsp_clone_count, rsp_cell_count,         rsp_strobe, no back-pressure
//           rsp_group_overflow
//
// An append that joins its group runs from accept to the next accept through one
// group-store read per stored member, up to GROUP_DEPTH, then the pipelined
// read-increment-write of the matrix memory. A clone count shows the cycle after its
// accept; a cell read passes the matrix read register and then the response register.
// After reset the matrix memory is cleared one entry a cycle, all 2^(2*ceil(log2(
// min(COMPONENT_COUNT,256)))) entries (65536 by default), with busy held high.
module group_cooccurrence_pair_counter_top
   import gcpc_pkg::*;
#(
   parameter int COMPONENT_COUNT = DEF_COMPONENT_COUNT,
   parameter int GROUP_DEPTH     = DEF_GROUP_DEPTH,
   parameter int COUNT_WIDTH     = DEF_COUNT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ACT_W-1:0]     req_action,
   input  logic [VERTEX_W-1:0]  req_vertex_label,
   input  logic [LCC_W-1:0]     req_lcc_index,
   input  logic [LCC_W-1:0]     req_read_src,
   input  logic [LCC_W-1:0]     req_read_tgt,
   output logic                 rsp_strobe,
   output logic                 rsp_result_kind,
   output logic [VERTEX_W-1:0]  rsp_done_vertex,
   output logic [CNT_OUT_W-1:0] rsp_clone_count,
   output logic [CNT_OUT_W-1:0] rsp_cell_count,
   output logic                 rsp_group_overflow
);

   localparam int CELL_ROWS = (COMPONENT_COUNT < (1 << LCC_W)) ? COMPONENT_COUNT
                                                               : (1 << LCC_W);
   localparam int ROW_W     = $clog2(CELL_ROWS);
   localparam int MAT_AW    = 2 * ROW_W;
   localparam int GD_W      = $clog2(GROUP_DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_SWEEP = 4'b0100,
      ST_DRAIN = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic                 open_ff, open_in;
   logic [VERTEX_W-1:0]  cur_vtx_ff, cur_vtx_in;
   logic [SIZE_W-1:0]    size_ff, size_in;
   logic                 ovf_ff, ovf_in;
   logic [GD_W-1:0]      j_ff, j_in;
   logic [GD_W-1:0]      last_ff, last_in;
   logic [LCC_W-1:0]     lcc_ff, lcc_in;
   logic                 rd_vld_ff, rd_vld_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [VERTEX_W-1:0]  rsp_vtx_ff, rsp_vtx_in;
   logic [CNT_OUT_W-1:0] rsp_clone_ff, rsp_clone_in;
   logic [CNT_OUT_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 store_we;
   logic [GD_W-1:0]      store_waddr;
   logic [LCC_W-1:0]     store_rdata;
   logic                 full;
   logic                 close_emit;

   cell_req_type         creq;
   logic [MAT_AW-1:0]    creq_addr;
   cell_done_type        cdone;
   logic [COUNT_WIDTH-1:0] cdone_count;
   logic                 clearing;

   gcpc_ram #(
      .WIDTH (LCC_W),
      .DEPTH (GROUP_DEPTH)
   ) u_group_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (req_lcc_index),
      .rd_en   (state_ff == ST_SWEEP),
      .rd_addr (j_ff),
      .rd_data (store_rdata)
   );

   gcpc_cell_unit #(
      .ADDR_W      (MAT_AW),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_cells (
      .clock      (clock),
      .reset      (reset),
      .req        (creq),
      .req_addr   (creq_addr),
      .clearing   (clearing),
      .done       (cdone),
      .done_count (cdone_count)
   );

   assign busy = (state_ff != ST_IDLE);
   // the new member cannot be stored once the store holds GROUP_DEPTH earlier ones
   assign full = (32'(size_ff) >= GROUP_DEPTH - 1);

   always_comb begin
      state_in    = state_ff;
      open_in     = open_ff;
      cur_vtx_in  = cur_vtx_ff;
      size_in     = size_ff;
      ovf_in      = ovf_ff;
      j_in        = j_ff;
      last_in     = last_ff;
      lcc_in      = lcc_ff;
      rd_vld_in   = 1'b0;
      store_we    = 1'b0;
      store_waddr = '0;
      close_emit  = 1'b0;
      creq        = '0;
      creq_addr   = {req_read_src[ROW_W-1:0], req_read_tgt[ROW_W-1:0]};

      unique case (state_ff)
         ST_CLEAR: begin
            if (!clearing) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               unique case (req_action)
                  ACT_APPEND: begin
                     if (open_ff && (req_vertex_label == cur_vtx_ff)) begin
                        lcc_in  = req_lcc_index;
                        j_in    = '0;
                        last_in = full ? GD_W'(GROUP_DEPTH - 1) : size_ff[GD_W-1:0];
                        if (full) begin
                           ovf_in = 1'b1;
                        end else begin
                           store_we    = 1'b1;
                           store_waddr = size_ff[GD_W-1:0] + 1'b1;
                        end
                        if (size_ff != '1) begin
                           size_in = size_ff + 1'b1;
                        end
                        state_in = ST_SWEEP;
                     end else begin
                        // close the old group, if any, and open a new one
                        close_emit  = open_ff;
                        open_in     = 1'b1;
                        cur_vtx_in  = req_vertex_label;
                        size_in     = '0;
                        store_we    = 1'b1;
                        store_waddr = '0;
                     end
                  end
                  ACT_FINISH: begin
                     close_emit = open_ff;
                     open_in    = 1'b0;
                     cur_vtx_in = '0;
                     size_in    = '0;
                  end
                  ACT_READ: begin
                     creq.vld = 1'b1;
                     creq.rd  = 1'b1;
                     creq.ok  = (32'(req_read_src) < COMPONENT_COUNT) &&
                                (32'(req_read_tgt) < COMPONENT_COUNT);
                     state_in = ST_DRAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            rd_vld_in = 1'b1;
            j_in      = j_ff + 1'b1;
            if (j_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // issue the matrix update for the stored member just read
      if (rd_vld_ff) begin
         creq.vld  = 1'b1;
         creq.rd   = 1'b0;
         creq.ok   = (32'(store_rdata) < COMPONENT_COUNT) &&
                     (32'(lcc_ff) < COMPONENT_COUNT);
         creq_addr = {store_rdata[ROW_W-1:0], lcc_ff[ROW_W-1:0]};
      end
   end

   always_comb begin
      rsp_strobe_in = close_emit || cdone.vld;
      rsp_kind_in   = rsp_kind_ff;
      rsp_vtx_in    = rsp_vtx_ff;
      rsp_clone_in  = rsp_clone_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (close_emit) begin
         rsp_kind_in  = KIND_CLONE;
         rsp_vtx_in   = cur_vtx_ff;
         rsp_clone_in = size_ff;
         rsp_cell_in  = '0;
         rsp_ovf_in   = ovf_ff;
      end else if (cdone.vld) begin
         rsp_kind_in  = KIND_CELL;
         rsp_vtx_in   = '0;
         rsp_clone_in = '0;
         rsp_cell_in  = cdone.ok ? CNT_OUT_W'(cdone_count) : '0;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         open_ff       <= 1'b0;
         cur_vtx_ff    <= '0;
         size_ff       <= '0;
         ovf_ff        <= 1'b0;
         j_ff          <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_ff       <= open_in;
         cur_vtx_ff    <= cur_vtx_in;
         size_ff       <= size_in;
         ovf_ff        <= ovf_in;
         j_ff          <= j_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      lcc_ff       <= lcc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_vtx_ff   <= rsp_vtx_in;
      rsp_clone_ff <= rsp_clone_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_done_vertex    = rsp_vtx_ff;
   assign rsp_clone_count    = rsp_clone_ff;
   assign rsp_cell_count     = rsp_cell_ff;
   assign rsp_group_overflow = rsp_ovf_ff;

   a_idle_no_store_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rd_vld_ff)
      else $error("group store read still in flight while idle");

   a_clear_holds_busy: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy)
      else $error("beat could be taken during matrix clear");

   a_cell_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_result_kind == KIND_CELL)) |-> $past(state_ff == ST_DRAIN))
      else $error("cell result without a preceding read");

   a_closed_group_clean: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> ((size_ff == '0) && (cur_vtx_ff == '0)))
      else $error("closed group left size or vertex behind");

endmodule
